// ===== rtl/hcc_pkg.sv =====
// ----------------------------------------------------------------------------
// HChaCha20 package
// Shared types, constants and step functions of the HChaCha20 subkey block.
// ----------------------------------------------------------------------------
package hcc_pkg;

   // Round structure: every double round is eight single steps.
   localparam int DOUBLE_ROUNDS   = 10;
   localparam int STEPS_PER_DBL   = 8;
   localparam int NUM_CELLS       = DOUBLE_ROUNDS * STEPS_PER_DBL;

   // Key register file.
   localparam int KEY_REGS        = 4;
   localparam int CSR_INDEX_WIDTH = $clog2(KEY_REGS);
   localparam int CSR_DATA_WIDTH  = 64;

   // Key register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_0 = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_1 = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_2 = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_3 = 2'd3;

   // The four ChaCha constant words.
   localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
   localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
   localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
   localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

   // Step phases of one quarter round.
   localparam logic [1:0] PHASE_ROT16 = 2'd0;
   localparam logic [1:0] PHASE_ROT12 = 2'd1;
   localparam logic [1:0] PHASE_ROT8  = 2'd2;
   localparam logic [1:0] PHASE_ROT7  = 2'd3;

   // Sixteen 32-bit words; element i is state word i.
   typedef logic [15:0][31:0] state_type;

   // Request and response payloads.
   typedef struct packed {
      logic [63:0] nonce_low;
      logic [63:0] nonce_high;
   } req_type;

   typedef struct packed {
      logic [63:0] subkey_part_0;
      logic [63:0] subkey_part_1;
      logic [63:0] subkey_part_2;
      logic [63:0] subkey_part_3;
   } rsp_type;

   // What one cell of the chain does: column or diagonal, and which step.
   typedef struct packed {
      logic       diag;
      logic [1:0] phase;
   } step_type;

   // Step assignment for the cell at a given position in the chain.
   function automatic step_type cell_step(int pos);
      logic [2:0] slot;
      step_type   step;
      slot       = 3'(pos);
      step.diag  = slot[2];
      step.phase = slot[1:0];
      return step;
   endfunction

   // State word index of one row of one quarter-round lane.
   function automatic logic [3:0] qr_index(logic diag, logic [1:0] lane, logic [1:0] row);
      logic [1:0] col;
      col = diag ? (lane + row) : lane;
      return {row, col};
   endfunction

   // Left rotation by the amount that belongs to the step phase.
   function automatic logic [31:0] rotl_phase(logic [31:0] v, logic [1:0] phase);
      logic [31:0] r;
      case (phase)
         PHASE_ROT16: r = {v[15:0], v[31:16]};
         PHASE_ROT12: r = {v[19:0], v[31:20]};
         PHASE_ROT8:  r = {v[23:0], v[31:24]};
         default:     r = {v[24:0], v[31:25]};
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/hcc_cell.sv =====
// ----------------------------------------------------------------------------
// HChaCha20 chain cell
// One add-xor-rotate step applied to four quarter-round lanes at once,
// followed by the state register that feeds the next cell.
// ----------------------------------------------------------------------------
module hcc_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  hcc_pkg::step_type   step,
   input  logic                in_valid,
   input  hcc_pkg::state_type  in_state,
   output logic                out_valid,
   output hcc_pkg::state_type  out_state
);
   import hcc_pkg::*;

   logic        valid_ff;
   state_type   state_ff;
   state_type   state_in;
   logic [1:0]  src_row;
   logic [1:0]  add_row;
   logic [1:0]  tgt_row;
   logic [31:0] sum_w [4];

   // Even phases add b into a and rotate d; odd phases add d into c and rotate b.
   assign src_row = step.phase[0] ? 2'd2 : 2'd0;
   assign add_row = src_row + 2'd1;
   assign tgt_row = step.phase[0] ? 2'd1 : 2'd3;

   // The four lanes are independent within one step.
   always_comb begin
      state_in = in_state;
      for (int lane = 0; lane < 4; lane++) begin
         sum_w[lane] = in_state[qr_index(step.diag, 2'(lane), src_row)]
                     + in_state[qr_index(step.diag, 2'(lane), add_row)];
         state_in[qr_index(step.diag, 2'(lane), src_row)] = sum_w[lane];
         state_in[qr_index(step.diag, 2'(lane), tgt_row)] =
            rotl_phase(in_state[qr_index(step.diag, 2'(lane), tgt_row)] ^ sum_w[lane],
                       step.phase);
      end
   end

   // Valid bit and state move on together whenever the chain advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

// ===== rtl/hchacha20_subkey_derivation.sv =====
// ----------------------------------------------------------------------------
// HChaCha20 subkey derivation
// Derives a 256-bit subkey from the configured key and a 128-bit nonce per
// request, through a chain of cells that each perform one round step.
// ----------------------------------------------------------------------------
//   channel   ports       direction   payload
//   request   req_*       in          nonce_low, nonce_high
//   response  rsp_*       out         subkey_part_0 .. subkey_part_3
//   config    csr_*       in          four 64-bit key registers
//
// A request enters the chain in the cycle it is accepted and its response appears
// once it has passed every cell (eight per double round, ten double rounds); one
// request is accepted every cycle unless the chain is stalled. Each cell does one
// add-xor-rotate step. Reset clears the cell valid bits and the key registers. A
// response that is not taken freezes the whole chain and drops req_ready.
// ----------------------------------------------------------------------------
module hchacha20_subkey_derivation (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  hcc_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output hcc_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_we,
   input  logic [hcc_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [hcc_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import hcc_pkg::*;

   logic [CSR_DATA_WIDTH-1:0] key_ff [KEY_REGS];
   logic                      advance;
   state_type                 init_state;
   state_type                 chain_state [NUM_CELLS+1];
   logic [NUM_CELLS:0]        chain_valid;
   state_type                 final_state;

   // Key registers, to be written by the user only while the block is idle; the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_REGS; i++) begin
            key_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_0: key_ff[0] <= csr_wdata;
            CSR_KEY_1: key_ff[1] <= csr_wdata;
            CSR_KEY_2: key_ff[2] <= csr_wdata;
            CSR_KEY_3: key_ff[3] <= csr_wdata;
            default:   ;
         endcase
      end
   end

   // The chain moves unless a finished response is waiting.
   assign advance   = !chain_valid[NUM_CELLS] || rsp_ready;
   assign req_ready = advance;

   // Initial state: constants, key words, then nonce words.
   always_comb begin
      init_state[0] = SIGMA_0;
      init_state[1] = SIGMA_1;
      init_state[2] = SIGMA_2;
      init_state[3] = SIGMA_3;
      for (int i = 0; i < KEY_REGS; i++) begin
         init_state[4 + 2*i] = key_ff[i][31:0];
         init_state[5 + 2*i] = key_ff[i][63:32];
      end
      init_state[12] = req_data.nonce_low[31:0];
      init_state[13] = req_data.nonce_low[63:32];
      init_state[14] = req_data.nonce_high[31:0];
      init_state[15] = req_data.nonce_high[63:32];
   end

   assign chain_valid[0] = req_valid;
   assign chain_state[0] = init_state;

   // The row of round-step cells.
   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      hcc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .step      (cell_step(g)),
         .in_valid  (chain_valid[g]),
         .in_state  (chain_state[g]),
         .out_valid (chain_valid[g+1]),
         .out_state (chain_state[g+1])
      );
   end

   // The last cell's register is the response register.
   assign final_state = chain_state[NUM_CELLS];
   assign rsp_valid   = chain_valid[NUM_CELLS];
   assign rsp_data.subkey_part_0 = {final_state[1],  final_state[0]};
   assign rsp_data.subkey_part_1 = {final_state[3],  final_state[2]};
   assign rsp_data.subkey_part_2 = {final_state[13], final_state[12]};
   assign rsp_data.subkey_part_3 = {final_state[15], final_state[14]};

`ifndef NO_ASSERTIONS
   // A stalled chain keeps every request where it is.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> $stable(chain_valid[NUM_CELLS:1]))
      else $error("chain moved while stalled");

   // Requests in flight change only by accepted requests and responses.
   assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |->
         $countones(chain_valid[NUM_CELLS:1]) ==
            $past($countones(chain_valid[NUM_CELLS:1]))
            + int'($past(req_valid && req_ready))
            - int'($past(rsp_valid && rsp_ready)))
      else $error("request lost or duplicated in chain");

   // A new response only shows up after the chain advanced.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_ready))
      else $error("response appeared without an advance");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HChaCha20 subkey derivation testbench
// Drives nonce requests through the valid/ready request channel under several
// key settings, predicts each subkey with a behavioral HChaCha20 in this file,
// and compares every response field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;

   // Bench constants, including the predictor's ChaCha sigma words and quarter-round lanes.
   localparam int          DOUBLE_ROUNDS   = 10;
   localparam int          CHAIN_LATENCY   = 80;
   localparam int          LONG_HOLD       = 300;
   localparam logic [31:0] CHACHA_SIGMA [4] = '{32'h61707865, 32'h3320646e,
                                                32'h79622d32, 32'h6b206574};
   localparam int          LANE_A [8] = '{0, 1, 2, 3, 0, 1, 2, 3};
   localparam int          LANE_B [8] = '{4, 5, 6, 7, 5, 6, 7, 4};
   localparam int          LANE_C [8] = '{8, 9, 10, 11, 10, 11, 8, 9};
   localparam int          LANE_D [8] = '{12, 13, 14, 15, 15, 12, 13, 14};
   localparam logic [hcc_pkg::CSR_INDEX_WIDTH-1:0] KEY_SLOT [4] =
      '{hcc_pkg::CSR_KEY_0, hcc_pkg::CSR_KEY_1, hcc_pkg::CSR_KEY_2, hcc_pkg::CSR_KEY_3};

   logic                                clock     = 1'b0;
   logic                                reset     = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   hcc_pkg::req_type                    req_data  = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   hcc_pkg::rsp_type                    rsp_data;
   logic                                csr_we    = 1'b0;
   logic [hcc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [hcc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // Local copy of the key registers and the subkeys still to come back.
   logic [3:0][63:0]  key_model = '0;
   hcc_pkg::rsp_type  pending_subkeys [$];
   hcc_pkg::rsp_type  expected_subkey;
   int                error_count    = 0;
   bit                sender_idling  = 1'b1;
   bit                sink_idling    = 1'b1;
   bit                hold_output    = 1'b0;

   hchacha20_subkey_derivation uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [31:0] rotate_left(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   // Full HChaCha20 on the current key and one nonce; no feed-forward.
   function automatic hcc_pkg::rsp_type derive_subkey(input hcc_pkg::req_type nonce);
      logic [31:0]      w [16];
      logic [31:0]      a, b, c, d;
      hcc_pkg::rsp_type result;
      for (int i = 0; i < 4; i++) begin
         w[i]         = CHACHA_SIGMA[i];
         w[4 + 2 * i] = key_model[i][31:0];
         w[5 + 2 * i] = key_model[i][63:32];
      end
      w[12] = nonce.nonce_low[31:0];
      w[13] = nonce.nonce_low[63:32];
      w[14] = nonce.nonce_high[31:0];
      w[15] = nonce.nonce_high[63:32];
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
         for (int q = 0; q < 8; q++) begin
            a = w[LANE_A[q]];
            b = w[LANE_B[q]];
            c = w[LANE_C[q]];
            d = w[LANE_D[q]];
            a = a + b; d = rotate_left(d ^ a, 16);
            c = c + d; b = rotate_left(b ^ c, 12);
            a = a + b; d = rotate_left(d ^ a, 8);
            c = c + d; b = rotate_left(b ^ c, 7);
            w[LANE_A[q]] = a;
            w[LANE_B[q]] = b;
            w[LANE_C[q]] = c;
            w[LANE_D[q]] = d;
         end
      end
      result.subkey_part_0 = {w[1], w[0]};
      result.subkey_part_1 = {w[3], w[2]};
      result.subkey_part_2 = {w[13], w[12]};
      result.subkey_part_3 = {w[15], w[14]};
      return result;
   endfunction

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
      end
   endtask

   // Response checker: every accepted response against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_subkeys.size() == 0) begin
            report_mismatch("response with no request pending");
         end else begin
            expected_subkey = pending_subkeys.pop_front();
            check_field("subkey_part_0", rsp_data.subkey_part_0, expected_subkey.subkey_part_0);
            check_field("subkey_part_1", rsp_data.subkey_part_1, expected_subkey.subkey_part_1);
            check_field("subkey_part_2", rsp_data.subkey_part_2, expected_subkey.subkey_part_2);
            check_field("subkey_part_3", rsp_data.subkey_part_3, expected_subkey.subkey_part_3);
         end
      end
   end

   // Response sink: random stall bursts, plus one long hold when asked for.
   initial begin : response_sink
      int burst;
      forever begin
         @(negedge clock);
         if (hold_output) begin
            hold_output = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (sink_idling && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 18);
            rsp_ready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one nonce, optionally after an idle burst, and wait for acceptance.
   task automatic send_nonce(input logic [63:0] low, input logic [63:0] high);
      hcc_pkg::req_type nonce;
      int               gap;
      nonce.nonce_low  = low;
      nonce.nonce_high = high;
      if (sender_idling && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 18);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= nonce;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_subkeys.push_back(derive_subkey(nonce));
   endtask

   // Stop offering and wait until every pending subkey has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_subkeys.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One key register write; the caller lowers the write enable afterwards.
   task automatic write_key_reg(input int slot, input logic [63:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= KEY_SLOT[slot];
      csr_wdata <= value;
      @(posedge clock);
      key_model[slot] = value;
   endtask

   task automatic load_key(input logic [3:0][63:0] key);
      for (int i = 0; i < 4; i++) begin
         write_key_reg(i, key[i]);
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_random_nonces(input int count);
      for (int i = 0; i < count; i++) begin
         send_nonce(random_word(), random_word());
      end
   endtask

   // Key still at its reset value of zero: field extremes, alternating bits and single set bits.
   task automatic test_zero_key();
      send_nonce(64'h0, 64'h0);
      send_nonce({64{1'b1}}, {64{1'b1}});
      send_nonce({32{2'b01}}, {32{2'b10}});
      send_nonce({32{2'b10}}, {32{2'b01}});
      send_nonce(64'h0, {64{1'b1}});
      send_nonce(64'h1, 64'h8000_0000_0000_0000);
      send_nonce(64'h8000_0000_0000_0000, 64'h1);
      send_nonce(64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000);
      wait_for_drain();
   endtask

   // The published HChaCha20 example key and nonce, plus a neighboring nonce and the zero nonce.
   task automatic test_known_vector();
      load_key({64'h1f1e1d1c1b1a1918, 64'h1716151413121110,
                64'h0f0e0d0c0b0a0908, 64'h0706050403020100});
      send_nonce(64'h4a000000_09000000, 64'h27594131_00000000);
      send_nonce(64'h4a000000_09000001, 64'h27594131_00000000);
      send_nonce(64'h0, 64'h0);
      wait_for_drain();
   endtask

   // All key bits set, then alternating key patterns.
   task automatic test_saturated_key();
      load_key({4{64'hffff_ffff_ffff_ffff}});
      send_nonce(64'h0, 64'h0);
      send_nonce({64{1'b1}}, {64{1'b1}});
      send_nonce({32{2'b01}}, {32{2'b10}});
      wait_for_drain();
      load_key({{32{2'b10}}, {32{2'b01}}, {32{2'b10}}, {32{2'b01}}});
      send_nonce({64{1'b1}}, 64'h0);
      send_nonce({32{2'b10}}, {32{2'b01}});
      wait_for_drain();
   endtask

   // Rewrite one key register at a time and confirm only it changes.
   task automatic test_single_register();
      for (int slot = 0; slot < 4; slot++) begin
         write_key_reg(slot, random_word());
         @(negedge clock);
         csr_we <= 1'b0;
         send_nonce(random_word(), random_word());
         send_nonce(64'h0, {64{1'b1}});
         wait_for_drain();
      end
   endtask

   // Several random keys, each with a batch of random nonces and idling.
   task automatic test_random_keys();
      for (int phase = 0; phase < 4; phase++) begin
         load_key({random_word(), random_word(), random_word(), random_word()});
         send_random_nonces(140);
         wait_for_drain();
      end
   endtask

   // The sink holds off for a long stretch while requests keep coming.
   task automatic test_output_hold();
      load_key({random_word(), random_word(), random_word(), random_word()});
      sender_idling = 1'b0;
      hold_output   = 1'b1;
      send_random_nonces(160);
      wait_for_drain();
      sender_idling = 1'b1;
   endtask

   // Back-to-back traffic with no idling on either side.
   task automatic test_full_rate();
      sender_idling = 1'b0;
      sink_idling   = 1'b0;
      load_key({random_word(), random_word(), random_word(), random_word()});
      send_random_nonces(150);
      wait_for_drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_zero_key();
      test_known_vector();
      test_saturated_key();
      test_single_register();
      test_random_keys();
      test_output_hold();
      test_full_rate();
      repeat (CHAIN_LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("hchacha20_subkey_derivation regression: pass");
      end else begin
         $display("hchacha20_subkey_derivation regression: fail");
      end
      $finish;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #2_000_000;
      $display("hchacha20_subkey_derivation regression: fail");
      $finish;
   end

endmodule
